/* design/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* design/vn3d_pkg.sv */
package vn3d_pkg;
    localparam int CompWidth  = 20;
    localparam int AbsWidth   = CompWidth;
    localparam int SumWidth   = 2 * AbsWidth + 2;
    localparam int MagWidth   = SumWidth / 2;
    localparam int FracBits   = 14;
    localparam int MagOutWidth  = 20;
    localparam int UnitOutWidth = 16;
    localparam int NumLanes   = 3;
    // dividend of one lane: |comp| << FracBits
    localparam int DivWidth   = AbsWidth + FracBits;
    // square root runs one result bit per pipeline stage
    localparam int SqrtSteps  = MagWidth;
    // each divider lane resolves one quotient bit per stage
    localparam int DivSteps   = DivWidth;

    typedef logic [AbsWidth-1:0] t_abs;
    typedef logic [SumWidth-1:0] t_sum;
    typedef logic [MagWidth-1:0] t_mag;
    typedef logic [DivWidth-1:0] t_quo;

    // sideband carried alongside each lane
    typedef struct packed {
        logic neg;
        logic zero;
    } t_lane_ctl;
endpackage

/* design/vn3d_sqrt.sv */
// Pipelined bit-by-bit square root, one result bit per stage.
module vn3d_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  vn3d_pkg::t_sum         i_sum,
    input  vn3d_pkg::t_abs         i_a0,
    input  vn3d_pkg::t_abs         i_a1,
    input  vn3d_pkg::t_abs         i_a2,
    input  logic [2:0]             i_neg,
    output logic                   o_valid,
    output vn3d_pkg::t_mag         o_mag,
    output vn3d_pkg::t_abs         o_a0,
    output vn3d_pkg::t_abs         o_a1,
    output vn3d_pkg::t_abs         o_a2,
    output logic [2:0]             o_neg
);
    localparam int N = vn3d_pkg::SqrtSteps;
    localparam int RW = vn3d_pkg::MagWidth + 2;

    logic                 r_v   [N+1];
    logic [RW-1:0]        r_rem [N+1];
    vn3d_pkg::t_mag       r_root[N+1];
    vn3d_pkg::t_sum       r_rad [N+1];
    vn3d_pkg::t_abs       r_a0  [N+1];
    vn3d_pkg::t_abs       r_a1  [N+1];
    vn3d_pkg::t_abs       r_a2  [N+1];
    logic [2:0]           r_neg [N+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_rad[0]  = i_sum;
        r_a0[0]   = i_a0;
        r_a1[0]   = i_a1;
        r_a2[0]   = i_a2;
        r_neg[0]  = i_neg;
    end

    // restoring square root: bring down two bits, try 4*root+1
    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_rem;
        logic [RW:0]   n_diff;
        always_comb begin
            n_trial = {r_rem[s][RW-3:0], r_rad[s][vn3d_pkg::SumWidth-1 -: 2]};
            n_diff  = {1'b0, n_trial} - {1'b0, r_root[s][vn3d_pkg::MagWidth-2:0], 2'b01};
            n_rem   = n_diff[RW] ? n_trial : n_diff[RW-1:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= {r_root[s][vn3d_pkg::MagWidth-2:0], ~n_diff[RW]};
                r_rad[s+1]  <= {r_rad[s][vn3d_pkg::SumWidth-3:0], 2'b00};
                r_a0[s+1]   <= r_a0[s];
                r_a1[s+1]   <= r_a1[s];
                r_a2[s+1]   <= r_a2[s];
                r_neg[s+1]  <= r_neg[s];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_mag   = r_root[N];
    assign o_a0    = r_a0[N];
    assign o_a1    = r_a1[N];
    assign o_a2    = r_a2[N];
    assign o_neg   = r_neg[N];
endmodule

/* design/vn3d_div_lane.sv */
// One divider lane: pipelined restoring division, one quotient bit per stage.
module vn3d_div_lane (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  vn3d_pkg::t_abs         i_a,
    input  vn3d_pkg::t_mag         i_mag,
    input  vn3d_pkg::t_lane_ctl    i_ctl,
    output logic [vn3d_pkg::UnitOutWidth-1:0] o_unit
);
    localparam int N  = vn3d_pkg::DivSteps;
    localparam int MW = vn3d_pkg::MagWidth;

    vn3d_pkg::t_quo      r_num [N+1];
    vn3d_pkg::t_quo      r_quo [N+1];
    logic [MW:0]         r_rem [N+1];
    vn3d_pkg::t_mag      r_den [N+1];
    vn3d_pkg::t_lane_ctl r_ctl [N+1];
    logic [vn3d_pkg::UnitOutWidth-1:0] r_out;

    always_comb begin
        r_num[0] = {i_a, {vn3d_pkg::FracBits{1'b0}}};
        r_quo[0] = '0;
        r_rem[0] = '0;
        r_den[0] = i_mag;
        r_ctl[0] = i_ctl;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [MW+1:0] n_sh;
        logic [MW+1:0] n_diff;
        always_comb begin
            n_sh   = {r_rem[s], r_num[s][vn3d_pkg::DivWidth-1]};
            n_diff = n_sh - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= {r_num[s][vn3d_pkg::DivWidth-2:0], 1'b0};
                r_quo[s+1] <= {r_quo[s][vn3d_pkg::DivWidth-2:0], ~n_diff[MW+1]};
                r_rem[s+1] <= n_diff[MW+1] ? n_sh[MW:0] : n_diff[MW:0];
                r_den[s+1] <= r_den[s];
                r_ctl[s+1] <= r_ctl[s];
            end
        end
    end

    // sign and null-vector handling
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ctl[N].zero) begin
                r_out <= '0;
            end else if (r_ctl[N].neg) begin
                r_out <= -r_quo[N][vn3d_pkg::UnitOutWidth-1:0];
            end else begin
                r_out <= r_quo[N][vn3d_pkg::UnitOutWidth-1:0];
            end
        end
    end
    assign o_unit = r_out;
endmodule

/* design/vector_normalize_3d.sv */
// Path: stage-1 register, then SqrtSteps square-root stages, then DivSteps divider stages
// and the lane output register, from input transfer to output transfer.
// Throughput: one vector per cycle while not stalled; the square root and the three divider
// lanes are fully pipelined, one bit per stage. Stall freezes the whole pipe.
// Reset (synchronous, active low) clears all valid bits; payload not reset.
module vector_normalize_3d (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [vn3d_pkg::CompWidth-1:0]    i_comp_x,
    input  logic signed [vn3d_pkg::CompWidth-1:0]    i_comp_y,
    input  logic signed [vn3d_pkg::CompWidth-1:0]    i_comp_z,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [vn3d_pkg::MagOutWidth-1:0]         o_magnitude,
    output logic signed [vn3d_pkg::UnitOutWidth-1:0] o_unit_x,
    output logic signed [vn3d_pkg::UnitOutWidth-1:0] o_unit_y,
    output logic signed [vn3d_pkg::UnitOutWidth-1:0] o_unit_z,
    output logic                    o_zero_length
);
    localparam int DLAT = vn3d_pkg::DivSteps + 1;

    logic en;
    logic r_v_sq;
    vn3d_pkg::t_abs r_a [3];
    logic [2:0]     r_neg;
    vn3d_pkg::t_sum r_sum;
    logic           sq_v;
    vn3d_pkg::t_mag sq_mag;
    vn3d_pkg::t_abs sq_a0, sq_a1, sq_a2;
    logic [2:0]     sq_neg;
    logic                 r_dv  [DLAT];
    vn3d_pkg::t_mag       r_dmag[DLAT];
    logic [vn3d_pkg::UnitOutWidth-1:0] unit [3];
    vn3d_pkg::t_lane_ctl  ctl [3];
    vn3d_pkg::t_abs       sq_a [3];
    logic [2*vn3d_pkg::AbsWidth-1:0] n_sq [3];
    vn3d_pkg::t_abs       n_abs [3];
    logic [vn3d_pkg::CompWidth-1:0] comp [3];

    // whole pipe advances unless a held result is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign comp[0] = i_comp_x;
    assign comp[1] = i_comp_y;
    assign comp[2] = i_comp_z;

    // stage 1: magnitudes and squares
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = comp[k][vn3d_pkg::CompWidth-1] ? -comp[k] : comp[k];
            n_sq[k]  = n_abs[k] * n_abs[k];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq <= 1'b0;
        end else if (en) begin
            r_v_sq <= i_valid;
        end
        if (en) begin
            for (int k = 0; k < 3; k++) r_a[k] <= n_abs[k];
            r_neg <= {comp[2][vn3d_pkg::CompWidth-1], comp[1][vn3d_pkg::CompWidth-1],
                      comp[0][vn3d_pkg::CompWidth-1]};
            r_sum <= vn3d_pkg::SumWidth'(n_sq[0]) + vn3d_pkg::SumWidth'(n_sq[1])
                   + vn3d_pkg::SumWidth'(n_sq[2]);
        end
    end

    vn3d_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v_sq),
        .i_sum(r_sum), .i_a0(r_a[0]), .i_a1(r_a[1]), .i_a2(r_a[2]), .i_neg(r_neg),
        .o_valid(sq_v), .o_mag(sq_mag), .o_a0(sq_a0), .o_a1(sq_a1), .o_a2(sq_a2),
        .o_neg(sq_neg)
    );

    assign sq_a[0] = sq_a0;
    assign sq_a[1] = sq_a1;
    assign sq_a[2] = sq_a2;

    // three lanes divide one component each
    for (genvar k = 0; k < vn3d_pkg::NumLanes; k++) begin : g_lane
        assign ctl[k].neg  = sq_neg[k];
        assign ctl[k].zero = (sq_mag == '0);
        vn3d_div_lane u_lane (
            .i_clk(i_clk), .i_en(en), .i_a(sq_a[k]), .i_mag(sq_mag),
            .i_ctl(ctl[k]), .o_unit(unit[k])
        );
    end

    // magnitude and valid travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DLAT; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= sq_v;
            for (int s = 1; s < DLAT; s++) r_dv[s] <= r_dv[s-1];
        end
        if (en) begin
            r_dmag[0] <= sq_mag;
            for (int s = 1; s < DLAT; s++) r_dmag[s] <= r_dmag[s-1];
        end
    end

    // merge stage
    assign o_valid       = r_dv[DLAT-1];
    assign o_magnitude   = r_dmag[DLAT-1][vn3d_pkg::MagOutWidth-1:0];
    assign o_zero_length = (r_dmag[DLAT-1] == '0);
    assign o_unit_x      = unit[0];
    assign o_unit_y      = unit[1];
    assign o_unit_z      = unit[2];

`include "assert_macros.svh"
    `ASSERT_IMPL(a_stall_only_held, i_clk, i_rst_n, o_stall |-> o_valid)
    `ASSERT_IMPL(a_zero_units, i_clk, i_rst_n,
        (o_valid && o_zero_length) |-> ({o_unit_x, o_unit_y, o_unit_z} == '0))
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_magnitude))
endmodule

/* verif/vector_normalize_3d_tb.sv */
`timescale 1ns / 1ps

module vector_normalize_3d_tb;

    localparam int PIPE_LAT   = vn3d_pkg::SqrtSteps + vn3d_pkg::DivSteps + 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [19:0]        magnitude;
        logic signed [15:0] unit_x;
        logic signed [15:0] unit_y;
        logic signed [15:0] unit_z;
        logic               zero_length;
    } t_norm;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [19:0] i_comp_x;
    logic signed [19:0] i_comp_y;
    logic signed [19:0] i_comp_z;
    logic               o_valid;
    logic               i_stall;
    logic [19:0]        o_magnitude;
    logic signed [15:0] o_unit_x;
    logic signed [15:0] o_unit_y;
    logic signed [15:0] o_unit_z;
    logic               o_zero_length;

    t_norm       expected_q[$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_null;
    int          idle_cycles;
    bit          quiet_mode;

    vector_normalize_3d dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // floor square root of the sum of squares, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // one lane of the unit vector: |c| << 14 / mag, sign restored
    function automatic logic [15:0] unit_lane(input logic [19:0] c, input logic [63:0] mag);
        logic [63:0] a;
        logic [63:0] q;
        a = c[19] ? {44'd0, -c} : {44'd0, c};
        q = (a << vn3d_pkg::FracBits) / mag;
        if (c[19]) q = -q;
        return q[15:0];
    endfunction

    function automatic t_norm normalize(input logic [19:0] x, input logic [19:0] y,
                                       input logic [19:0] z);
        t_norm       r;
        logic [63:0] ax, ay, az, mag;
        ax  = x[19] ? {44'd0, -x} : {44'd0, x};
        ay  = y[19] ? {44'd0, -y} : {44'd0, y};
        az  = z[19] ? {44'd0, -z} : {44'd0, z};
        mag = floor_sqrt(ax * ax + ay * ay + az * az);
        r.magnitude = mag[19:0];
        if (mag == 0) begin
            r.unit_x = '0;
            r.unit_y = '0;
            r.unit_z = '0;
            r.zero_length = 1'b1;
        end else begin
            r.unit_x = unit_lane(x, mag);
            r.unit_y = unit_lane(y, mag);
            r.unit_z = unit_lane(z, mag);
            r.zero_length = 1'b0;
        end
        return r;
    endfunction

    // send one vector; gaps at random unless quiet; valid stays up after the transfer
    task automatic send_vector(input logic [19:0] x, input logic [19:0] y,
                               input logic [19:0] z);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_q.push_back(normalize(x, y, z));
        n_sent++;
        if (x == 0 && y == 0 && z == 0) n_null++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else          i_stall <= !quiet_mode && ($urandom_range(99) < 9);
    end

    // result checker
    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("result with no vector outstanding");
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                n_checked++;
                if (o_magnitude !== e.magnitude) begin
                    $error("magnitude exp %0d got %0d", e.magnitude, o_magnitude);
                    n_errors++;
                end
                if (o_unit_x !== e.unit_x) begin
                    $error("unit_x exp %0d got %0d", e.unit_x, o_unit_x);
                    n_errors++;
                end
                if (o_unit_y !== e.unit_y) begin
                    $error("unit_y exp %0d got %0d", e.unit_y, o_unit_y);
                    n_errors++;
                end
                if (o_unit_z !== e.unit_z) begin
                    $error("unit_z exp %0d got %0d", e.unit_z, o_unit_z);
                    n_errors++;
                end
                if (o_zero_length !== e.zero_length) begin
                    $error("zero_length exp %0d got %0d", e.zero_length, o_zero_length);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [19:0] rand_comp();
        case ($urandom_range(5))
            0:       return 20'(int'($urandom_range(512)) - 256);
            1:       return 20'h80000;
            2:       return 20'h7ffff;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_vector(20'h0, 20'h0, 20'h0);
        send_vector(20'h7ffff, 20'h7ffff, 20'h7ffff);
        send_vector(20'h80000, 20'h80000, 20'h80000);
        send_vector(20'h80000, 20'h7ffff, 20'h0);
        send_vector(20'h7ffff, 20'h0, 20'h0);
        send_vector(20'h0, 20'h80000, 20'h0);
        send_vector(20'h0, 20'h0, 20'h00001);
        send_vector(20'hfffff, 20'h0, 20'h0);
        send_vector(20'h00001, 20'hfffff, 20'h00001);
        send_vector(20'h00100, 20'h00100, 20'h00100);
        send_vector(20'hfff00, 20'h00200, 20'hffe00);
        send_vector(20'h0, 20'h0, 20'h0);
        send_vector(20'h55555, 20'haaaaa, 20'h3c3c3);
    endtask

    // sender holds off until the pipe is empty
    task automatic test_pipe_drain();
        drain_results();
        send_vector(20'h00300, 20'hffc00, 20'h00500);
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] z;
        for (int i = 0; i < count; i++) begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if ($urandom_range(49) == 0) begin
                x = '0;
                y = '0;
                z = '0;
            end
            send_vector(x, y, z);
        end
    endtask

    task automatic test_back_to_back(input int count);
        quiet_mode = 1'b1;
        test_random(count);
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_comp_x    = '0;
        i_comp_y    = '0;
        i_comp_z    = '0;
        n_errors    = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_null      = 0;
        idle_cycles = 0;
        quiet_mode  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_pipe_drain();
        test_random(900);
        test_back_to_back(300);
        test_random(730);

        drain_results();
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        $display("Covered %0d vectors (%0d null), %0d results checked, with random gaps",
                 n_sent, n_null, n_checked);
        $display("and stalls on both sides plus one back-to-back stretch.");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
